@@ rtl/bch4_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bch4_pkg;

  localparam int GF_M = 13;
  localparam logic [GF_M-1:0] GF_POLY = 13'h05AF;
  localparam int FIELD_N = 8191;
  localparam int CHECK_BITS = 52;
  localparam int MAX_T = 4;
  localparam int CHIEN_LANES = 8;
  localparam int JOB_QUEUE_DEPTH = 2;
  localparam logic [9:0] DATA_BYTES_RESET = 10'd512;

  typedef logic [GF_M-1:0] gf_t;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_CLEAN  = 2'd1,
    KIND_FAIL   = 2'd2
  } kind_t;

  // Locator handed from Berlekamp-Massey to the Chien search.
  typedef struct packed {
    kind_t         kind;
    logic [2:0]    ldeg;
    gf_t [MAX_T:0] coef;
  } job_t;

  function automatic gf_t gf_xtime(gf_t a);
    return {a[GF_M-2:0], 1'b0} ^ (a[GF_M-1] ? GF_POLY : '0);
  endfunction

  function automatic gf_t gf_mul(gf_t a, gf_t b);
    gf_t acc;
    acc = '0;
    for (int i = GF_M - 1; i >= 0; i--) begin
      acc = gf_xtime(acc) ^ (b[i] ? a : '0);
    end
    return acc;
  endfunction

  // Only ever called with constant arguments, so it folds to a constant.
  function automatic gf_t alpha_exp(int n);
    gf_t x;
    x = gf_t'(1);
    for (int i = 0; i < n; i++) begin
      x = gf_xtime(x);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bch_t4_error_locator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Error locator for a 4-bit-correcting binary BCH code over GF(2^13).
// Input channel (in_*): one beat carries the four odd syndromes S1, S3, S5
// and S7 of one codeword. Output channel (out_*): one beat per error found,
// holding its bit location and the error count, tlast on the final beat.
// A clean codeword gives a single beat with count zero; a failed decode gives
// a single beat with out_tuser set.
// cfg_wr_en/cfg_wr_data set the data length in bytes (512 after reset); the
// code covers eight times that plus 52 check bits, at most 8191 bits.
// A Berlekamp-Massey unit, bound by the field inversion in each update step,
// works out the locator of each beat and hands it through a short queue to
// the Chien search. The search tests LANES positions a cycle until it has
// found as many roots as the locator degree or has reached the end of the
// code. Reset empties the queue and returns both parts to idle. When the
// receiver stalls, the result waits in the output register, the search
// holds, and further syndrome sets queue up until the queue is full.
module bch_t4_error_locator
  import bch4_pkg::*;
#(
  parameter int LANES       = CHIEN_LANES,
  parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // syndrome_1, syndrome_3, syndrome_5, syndrome_7
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // error_location, error_count
  output logic             out_tuser,  // decode_failed
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data
);

  logic [9:0] data_bytes_r;
  logic bm_valid, bm_ready, q_valid, q_ready;
  job_t bm_job, q_job;
  logic [$bits(job_t)-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bytes_r <= DATA_BYTES_RESET;
    end else if (cfg_wr_en) begin
      data_bytes_r <= cfg_wr_data;
    end
  end

  bch4_bm u_bm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (bm_valid),
    .job_ready (bm_ready),
    .job       (bm_job)
  );

  bch4_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (bm_valid),
    .wr_ready (bm_ready),
    .wr_data  (bm_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_job = job_t'(q_data);

  bch4_chien #(
    .LANES (LANES)
  ) u_chien (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_bytes (data_bytes_r),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job        (q_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/bch4_gfpow.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bch4_gfpow
  import bch4_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire gf_t             base,
  input  wire logic [GF_M-1:0] expo,
  output logic                 done,
  output gf_t                  result
);

  localparam int CW = $clog2(GF_M + 1);

  gf_t acc_r, acc_nxt, b_r, b_nxt;
  logic [GF_M-1:0] e_r, e_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    e_nxt    = e_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = gf_t'(1);
      b_nxt    = base;
      e_nxt    = expo;
      cnt_nxt  = CW'(GF_M);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Right-to-left square and multiply, one exponent bit a cycle.
      if (e_r[0]) begin
        acc_nxt = gf_mul(acc_r, b_r);
      end
      b_nxt   = gf_mul(b_r, b_r);
      e_nxt   = e_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    e_r   <= e_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

@@ rtl/bch4_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bch4_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bch4_bm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bch4_bm
  import bch4_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_SQ   = 8'b0000_0010,
    F_STEP = 8'b0000_0100,
    F_INV  = 8'b0000_1000,
    F_UPD  = 8'b0001_0000,
    F_ADV  = 8'b0010_0000,
    F_DISC = 8'b0100_0000,
    F_PUSH = 8'b1000_0000
  } fstate_t;

  fstate_t state_r, state_nxt;

  gf_t s_r [8], s_nxt [8];
  gf_t lam_r [12], lam_nxt [12];
  gf_t prev_r [5], prev_nxt [5];
  gf_t keep_r [5], keep_nxt [5];
  logic [3:0] ldeg_r, ldeg_nxt;
  logic [2:0] kdeg_r, kdeg_nxt, pdeg_r, pdeg_nxt;
  gf_t pd_r, pd_nxt, d_r, d_nxt, f_r, f_nxt;
  // Previous update step plus one, so that "none yet" is zero.
  logic [2:0] ppp_r, ppp_nxt;
  logic [1:0] i_r, i_nxt;
  logic [2:0] j_r, j_nxt;

  logic [3:0] k_w, idx_w;
  logic [2:0] m_w;
  logic pow_start, pow_done;
  gf_t pow_result;

  assign k_w   = 4'({i_r, 1'b1}) - 4'(ppp_r);
  assign idx_w = 4'(j_r) + k_w;
  assign m_w   = {i_r, 1'b0};

  bch4_gfpow u_inv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (pow_start),
    .base   (pd_r),
    .expo   (13'd8190),
    .done   (pow_done),
    .result (pow_result)
  );

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    lam_nxt   = lam_r;
    prev_nxt  = prev_r;
    keep_nxt  = keep_r;
    ldeg_nxt  = ldeg_r;
    kdeg_nxt  = kdeg_r;
    pdeg_nxt  = pdeg_r;
    pd_nxt    = pd_r;
    d_nxt     = d_r;
    f_nxt     = f_r;
    ppp_nxt   = ppp_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pow_start = 1'b0;
    in_tready = 1'b0;
    job_valid = 1'b0;

    unique case (state_r)
      F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          s_nxt[0] = in_tdata[12:0];
          s_nxt[2] = in_tdata[25:13];
          s_nxt[4] = in_tdata[38:26];
          s_nxt[6] = in_tdata[51:39];
          for (int n = 0; n < 12; n++) begin
            lam_nxt[n] = '0;
          end
          for (int n = 0; n < 5; n++) begin
            prev_nxt[n] = '0;
          end
          lam_nxt[0]  = gf_t'(1);
          prev_nxt[0] = gf_t'(1);
          ldeg_nxt    = '0;
          pdeg_nxt    = '0;
          pd_nxt      = gf_t'(1);
          ppp_nxt     = '0;
          d_nxt       = in_tdata[12:0];
          i_nxt       = '0;
          j_nxt       = '0;
          state_nxt   = F_SQ;
        end
      end
      F_SQ: begin
        // Even syndromes follow from S(2i) = S(i) squared; the state repeats until
        // the chain through S2, S4 and S8 has settled.
        s_nxt[1] = gf_mul(s_r[0], s_r[0]);
        s_nxt[3] = gf_mul(s_r[1], s_r[1]);
        s_nxt[5] = gf_mul(s_r[2], s_r[2]);
        s_nxt[7] = gf_mul(s_r[3], s_r[3]);
        j_nxt    = j_r + 1'b1;
        if (j_r == 3'd2) begin
          state_nxt = F_STEP;
        end
      end
      F_STEP: begin
        if (d_r != '0) begin
          pow_start = 1'b1;
          for (int n = 0; n < 5; n++) begin
            keep_nxt[n] = lam_r[n];
          end
          kdeg_nxt  = ldeg_r[2:0];
          state_nxt = F_INV;
        end else begin
          state_nxt = F_ADV;
        end
      end
      F_INV: begin
        if (pow_done) begin
          f_nxt     = gf_mul(d_r, pow_result);
          j_nxt     = '0;
          state_nxt = F_UPD;
        end
      end
      F_UPD: begin
        lam_nxt[idx_w] = lam_r[idx_w] ^ gf_mul(f_r, prev_r[j_r]);
        if (j_r == pdeg_r) begin
          if (4'(pdeg_r) + k_w > ldeg_r) begin
            ldeg_nxt = 4'(pdeg_r) + k_w;
            prev_nxt = keep_r;
            pdeg_nxt = kdeg_r;
            pd_nxt   = d_r;
            ppp_nxt  = {i_r, 1'b1};
          end
          state_nxt = F_ADV;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      F_ADV: begin
        if (ldeg_r > 4'(MAX_T) || i_r == 2'd3) begin
          state_nxt = F_PUSH;
        end else begin
          d_nxt = s_r[{i_r + 2'd1, 1'b0}];
          i_nxt = i_r + 1'b1;
          j_nxt = 3'd1;
          state_nxt = (ldeg_r == '0) ? F_STEP : F_DISC;
        end
      end
      F_DISC: begin
        d_nxt = d_r ^ gf_mul(lam_r[4'(j_r)], s_r[m_w - j_r]);
        if (4'(j_r) == ldeg_r || j_r == m_w) begin
          state_nxt = F_STEP;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    if (ldeg_r > 4'(MAX_T)) begin
      job.kind = KIND_FAIL;
    end else if (ldeg_r == '0) begin
      job.kind = KIND_CLEAN;
    end else begin
      job.kind = KIND_SEARCH;
    end
    job.ldeg = ldeg_r[2:0];
    // A vanished leading coefficient is taken as one.
    for (int n = 0; n <= MAX_T; n++) begin
      job.coef[n] = lam_r[n];
      if (4'(n) == ldeg_r && lam_r[n] == '0) begin
        job.coef[n] = gf_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    lam_r  <= lam_nxt;
    prev_r <= prev_nxt;
    keep_r <= keep_nxt;
    ldeg_r <= ldeg_nxt;
    kdeg_r <= kdeg_nxt;
    pdeg_r <= pdeg_nxt;
    pd_r   <= pd_nxt;
    d_r    <= d_nxt;
    f_r    <= f_nxt;
    ppp_r  <= ppp_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/bch4_chien.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bch4_chien
  import bch4_pkg::*;
#(
  parameter int LANES = CHIEN_LANES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [9:0]  data_bytes,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  wire job_t        job,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_POW  = 5'b00010,
    B_INIT = 5'b00100,
    B_RUN  = 5'b01000,
    B_EMIT = 5'b10000
  } bstate_t;

  bstate_t state_r, state_nxt;
  job_t job_r, job_nxt;
  logic [13:0] nbits_r, nbits_nxt, off_r, off_nxt;
  gf_t x_r, x_nxt, p_r, p_nxt;
  gf_t r_r [MAX_T], r_nxt [MAX_T];
  gf_t roots_r [MAX_T], roots_nxt [MAX_T];
  logic [1:0] jj_r, jj_nxt, n_r, n_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic fail_r, fail_nxt;

  logic out_valid_r, out_valid_nxt, out_fail_r, out_fail_nxt, out_last_r, out_last_nxt;
  gf_t out_loc_r, out_loc_nxt;
  logic [2:0] out_cnt_r, out_cnt_nxt;

  logic [13:0] nbits_w, sum_w, start_w;
  logic pow_start, pow_done, out_free, emit_last;
  gf_t pow_result;

  assign sum_w   = 14'({data_bytes, 3'b000}) + 14'(CHECK_BITS);
  assign nbits_w = (sum_w > 14'(FIELD_N)) ? 14'(FIELD_N) : sum_w;
  assign start_w = 14'(FIELD_N + 1) - nbits_w;
  assign out_free  = !out_valid_r || out_tready;
  assign emit_last = fail_r || (cnt_r == '0) || (3'(n_r) == cnt_r - 3'd1);

  bch4_gfpow u_start (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (pow_start),
    .base   (gf_t'(2)),
    .expo   (start_w[GF_M-1:0]),
    .done   (pow_done),
    .result (pow_result)
  );

  always_comb begin
    gf_t val;
    logic [2:0] c;
    logic hit;

    state_nxt     = state_r;
    job_nxt       = job_r;
    nbits_nxt     = nbits_r;
    off_nxt       = off_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    roots_nxt     = roots_r;
    jj_nxt        = jj_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_loc_nxt   = out_loc_r;
    out_cnt_nxt   = out_cnt_r;
    out_fail_nxt  = out_fail_r;
    out_last_nxt  = out_last_r;
    pow_start     = 1'b0;
    job_ready     = 1'b0;
    c             = cnt_r;
    val           = '0;
    hit           = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          job_nxt   = job;
          nbits_nxt = nbits_w;
          cnt_nxt   = '0;
          n_nxt     = '0;
          fail_nxt  = (job.kind == KIND_FAIL);
          if (job.kind == KIND_SEARCH) begin
            pow_start = 1'b1;
            state_nxt = B_POW;
          end else begin
            state_nxt = B_EMIT;
          end
        end
      end
      B_POW: begin
        if (pow_done) begin
          x_nxt     = pow_result;
          p_nxt     = pow_result;
          jj_nxt    = '0;
          state_nxt = B_INIT;
        end
      end
      B_INIT: begin
        // Term j starts at coef(j) times alpha to the power j*start.
        r_nxt[jj_r] = gf_mul(job_r.coef[3'(jj_r) + 3'd1], p_r);
        p_nxt       = gf_mul(p_r, x_r);
        jj_nxt      = jj_r + 1'b1;
        if (jj_r == 2'd3) begin
          off_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        for (int m = 0; m < LANES; m++) begin
          val = job_r.coef[0];
          for (int j = 0; j < MAX_T; j++) begin
            val = val ^ gf_mul(r_r[j], alpha_exp((j + 1) * m));
          end
          hit = (off_r + 14'(m) < nbits_r) && (val == '0);
          if (hit && c < job_r.ldeg) begin
            roots_nxt[c[1:0]] = 13'(off_r + 14'(m));
            c = c + 3'd1;
          end
        end
        for (int j = 0; j < MAX_T; j++) begin
          r_nxt[j] = gf_mul(r_r[j], alpha_exp((j + 1) * LANES));
        end
        off_nxt = off_r + 14'(LANES);
        cnt_nxt = c;
        if (c == job_r.ldeg || off_r + 14'(LANES) >= nbits_r) begin
          fail_nxt  = (c != job_r.ldeg);
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_fail_nxt  = fail_r;
          out_last_nxt  = emit_last;
          if (fail_r || cnt_r == '0) begin
            out_loc_nxt = '0;
            out_cnt_nxt = '0;
          end else begin
            // Bit order within a byte is reversed.
            out_loc_nxt = roots_r[n_r] ^ gf_t'(7);
            out_cnt_nxt = cnt_r;
          end
          n_nxt = n_r + 1'b1;
          if (emit_last) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    nbits_r    <= nbits_nxt;
    off_r      <= off_nxt;
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    roots_r    <= roots_nxt;
    jj_r       <= jj_nxt;
    n_r        <= n_nxt;
    cnt_r      <= cnt_nxt;
    fail_r     <= fail_nxt;
    out_loc_r  <= out_loc_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_fail_r <= out_fail_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_loc_r};
  assign out_tuser  = out_fail_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_run_has_locator: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RUN |-> job_r.kind == KIND_SEARCH && job_r.ldeg != '0 &&
                         job_r.ldeg <= 3'(MAX_T))
    else $error("Chien search running without a valid locator");
  a_roots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN || state_r == B_EMIT) |-> cnt_r <= job_r.ldeg)
    else $error("more roots recorded than the locator degree");
  a_fail_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fail_r |-> out_last_r && out_cnt_r == '0 && out_loc_r == '0)
    else $error("failure beat carries a count or location");
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_fail_r && out_cnt_r == '0 |-> out_last_r)
    else $error("clean result not marked last");
`endif

endmodule

`default_nettype wire

@@ tb/bch_t4_locator_checker.sv @@
`timescale 1ns / 1ps

module bch_t4_locator_checker
  import bch4_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [55:0] in_tdata,   // syndrome_1, syndrome_3, syndrome_5, syndrome_7
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // error_location, error_count
  input  wire logic        out_tuser,  // decode_failed
  input  wire logic        out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [12:0] location;
    logic [2:0]  count;
    logic        failed;
    logic        last;
  } locator_beat_t;

  int            antilog [0:8191];
  int            gf_log  [0:8191];
  logic [9:0]    byte_len;
  locator_beat_t located_q[$];

  initial begin
    int x;
    x = 1;
    for (int i = 0; i < 8191; i++) begin
      antilog[i] = x;
      gf_log[x] = i;
      x = x << 1;
      if (x & 'h2000) x = x ^ 'h25AF;
    end
    antilog[8191] = 1;
    gf_log[0] = 0;
    fail_count = 0;
    pending = 0;
    byte_len = DATA_BYTES_RESET;
  end

  function automatic int gf_prod(int a, int b);
    if (a == 0 || b == 0) return 0;
    return antilog[(gf_log[a] + gf_log[b]) % 8191];
  endfunction

  function automatic void push_beat(int loc, int cnt, bit failed, bit last);
    locator_beat_t b;
    b.location = loc[12:0];
    b.count = cnt[2:0];
    b.failed = failed;
    b.last = last;
    located_q.push_back(b);
  endfunction

  // Berlekamp-Massey on the derived syndrome set, then a Chien search.
  function automatic void locate_errors(logic [55:0] syn);
    int s[8];
    int lam[16], prev[16], keep[16];
    int ldeg, pdeg, kdeg, d, pd, pp, k, sh, idx, lead, v0, val, cnt, nbits, loc;
    int rep[16];
    int roots[4];
    bit bad;
    for (int i = 0; i < 4; i++) s[2 * i] = int'(syn[13 * i +: 13]);
    for (int i = 0; i < 4; i++)
      s[2 * i + 1] = (s[i] == 0) ? 0 : antilog[(2 * gf_log[s[i]]) % 8191];
    for (int j = 0; j < 16; j++) begin
      lam[j] = 0;
      prev[j] = 0;
    end
    lam[0] = 1;
    prev[0] = 1;
    ldeg = 0;
    pdeg = 0;
    pd = 1;
    pp = -1;
    d = s[0];
    for (int i = 0; i < 4 && ldeg <= 4; i++) begin
      if (d != 0) begin
        k = 2 * i - pp;
        sh = gf_log[d] + 8191 - gf_log[pd];
        keep = lam;
        kdeg = ldeg;
        for (int j = 0; j <= pdeg; j++) begin
          idx = j + k;
          if (prev[j] != 0 && idx < 16)
            lam[idx] ^= antilog[(sh + gf_log[prev[j]]) % 8191];
        end
        if (pdeg + k > ldeg) begin
          ldeg = pdeg + k;
          prev = keep;
          pdeg = kdeg;
          pd = d;
          pp = 2 * i;
        end
      end
      if (i < 3) begin
        d = s[2 * i + 2];
        for (int j = 1; j <= ldeg && j < 16; j++)
          if (j <= 2 * i + 2) d ^= gf_prod(lam[j], s[2 * i + 2 - j]);
      end
    end
    if (ldeg > 4) begin
      push_beat(0, 0, 1'b1, 1'b1);
      return;
    end
    if (ldeg == 0) begin
      push_beat(0, 0, 1'b0, 1'b1);
      return;
    end
    nbits = 8 * int'(byte_len) + 52;
    if (nbits > 8191) nbits = 8191;
    // A zero leading coefficient reads as log 0, i.e. as one.
    lead = gf_log[lam[ldeg]];
    for (int j = 0; j < ldeg; j++)
      rep[j] = (lam[j] != 0) ? (gf_log[lam[j]] + 8191 - lead) % 8191 : -1;
    rep[ldeg] = 0;
    v0 = (lam[0] != 0) ? antilog[(gf_log[lam[0]] + 8191 - lead) % 8191] : 0;
    cnt = 0;
    for (int p = 8191 - nbits + 1; p <= 8191; p++) begin
      val = v0;
      for (int j = 1; j <= ldeg; j++)
        if (rep[j] >= 0) val ^= antilog[(rep[j] + j * p) % 8191];
      if (val == 0) begin
        roots[cnt] = 8191 - p;
        cnt++;
        if (cnt == ldeg) break;
      end
    end
    bad = (cnt != ldeg);
    for (int n = 0; n < cnt; n++)
      if (roots[n] >= nbits) bad = 1'b1;
    if (bad) begin
      push_beat(0, 0, 1'b1, 1'b1);
      return;
    end
    for (int n = 0; n < cnt; n++) begin
      loc = nbits - 1 - roots[n];
      loc = (loc & ~7) | (7 - (loc & 7));
      push_beat(loc, cnt, 1'b0, n == cnt - 1);
    end
  endfunction

  always @(posedge clk) begin
    locator_beat_t want, got;
    if (!rst_n) begin
      byte_len = DATA_BYTES_RESET;
      located_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[12:0], out_tdata[15:13], out_tuser, out_tlast};
        if (located_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat loc=%0d cnt=%0d fail=%0b last=%0b",
                     got.location, got.count, got.failed, got.last);
          fail_count++;
        end else begin
          want = located_q.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("mismatch: expected loc=%0d cnt=%0d fail=%0b last=%0b,",
                       want.location, want.count, want.failed, want.last,
                       " got loc=%0d cnt=%0d fail=%0b last=%0b",
                       got.location, got.count, got.failed, got.last);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) byte_len = cfg_wr_data;
      if (in_tvalid && in_tready) locate_errors(in_tdata);
    end
    pending = located_q.size();
  end

endmodule

@@ tb/tb_bch_t4_error_locator.sv @@
`timescale 1ns / 1ps

module tb_bch_t4_error_locator;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // syndrome_1, syndrome_3, syndrome_5, syndrome_7
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // error_location, error_count
  logic        out_tuser;  // decode_failed
  logic        out_tlast;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;
  int          fail_count;
  int          pending;
  int          code_bits;
  bit          hold_req;

  bch_t4_error_locator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  bch_t4_locator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("bch_t4_error_locator regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  function automatic int alpha_pow(int n);
    int x;
    x = 1;
    for (int i = 0; i < n % 8191; i++) begin
      x = x << 1;
      if (x & 'h2000) x = x ^ 'h25AF;
    end
    return x;
  endfunction

  // Odd syndromes of a received word whose errors sit at the given exponents.
  function automatic logic [55:0] syndromes_of(int roots[$]);
    int s[4];
    for (int k = 0; k < 4; k++) s[k] = 0;
    foreach (roots[i])
      for (int k = 0; k < 4; k++) s[k] ^= alpha_pow((2 * k + 1) * roots[i]);
    return {4'b0, s[3][12:0], s[2][12:0], s[1][12:0], s[0][12:0]};
  endfunction

  function automatic logic [55:0] random_error_set(int nerr, int lo, int hi);
    int roots[$];
    int r;
    bit dup;
    while (roots.size() < nerr) begin
      r = $urandom_range(hi, lo);
      dup = 1'b0;
      foreach (roots[i]) if (roots[i] == r) dup = 1'b1;
      if (!dup) roots.push_back(r);
    end
    return syndromes_of(roots);
  endfunction

  function automatic logic [55:0] random_syndromes();
    int sel;
    logic [55:0] v;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel <= 6) return random_error_set($urandom_range(4, 1), 0, code_bits - 1);
    if (sel == 7) return random_error_set($urandom_range(8, 5), 0, code_bits - 1);
    if (sel == 9 && code_bits < 8191) begin
      // One error inside the code and one beyond its end.
      v = random_error_set(1, 0, code_bits - 1) ^ random_error_set(1, code_bits, 8190);
      return v;
    end
    v = 56'({$urandom, $urandom});
    v[55:52] = '0;
    return v;
  endfunction

  task automatic send_beat(logic [55:0] syn);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= syn;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_length(logic [9:0] bytes);
    int n;
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bytes;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n = 8 * int'(bytes) + 52;
    code_bits = (n > 8191) ? 8191 : n;
  endtask

  task automatic random_phase(int items);
    for (int i = 0; i < items; i++) send_beat(random_syndromes());
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    int len;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (4000) @(posedge clk);
      end
      len = $urandom_range(99) < 20 ? $urandom_range(200, 50) : $urandom_range(8, 1);
      out_tready <= 1'b1;
      repeat (len) @(posedge clk);
      len = pick_gap();
      if (len > 0) begin
        out_tready <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    int q[$];
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    code_bits = 8 * 512 + 52;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at the reset length.
    send_beat('0);
    send_beat({4'b0, {4{13'h1FFF}}});
    q = '{0};
    send_beat(syndromes_of(q));
    q = '{code_bits - 1};
    send_beat(syndromes_of(q));
    q = '{0, 1, 2, code_bits - 1};
    send_beat(syndromes_of(q));
    q = '{3, 100, 2000, 4000, 4100};
    send_beat(syndromes_of(q));
    q = '{code_bits, 8190};
    send_beat(syndromes_of(q));
    send_beat({4'b0, 13'h0F0F, 13'h1234, 13'h0ABC, 13'h0});
    random_phase(10);
    // The block fills up behind a long output stall.
    hold_req = 1'b1;
    random_phase(30);
    drain();

    set_length(10'd0);
    q = '{0, 51};
    send_beat(syndromes_of(q));
    random_phase(20);
    drain();
    set_length(10'd1);
    random_phase(20);
    drain();
    set_length(10'd1023);
    q = '{8190};
    send_beat(syndromes_of(q));
    random_phase(10);
    drain();
    set_length(10'd1017);
    q = '{0, 8187, 8188, 8189};
    send_beat(syndromes_of(q));
    random_phase(10);
    drain();
    set_length(10'd64);
    random_phase(30);
    drain();
    set_length(10'($urandom_range(1016, 2)));
    random_phase(30);
    drain();
    set_length(10'd300);
    random_phase(30);
    drain();

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("bch_t4_error_locator regression: pass");
    end else begin
      $display("bch_t4_error_locator regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bch4_pkg.sv
rtl/bch4_gfpow.sv
rtl/bch4_fifo.sv
rtl/bch4_bm.sv
rtl/bch4_chien.sv
rtl/bch_t4_error_locator.sv
tb/bch_t4_locator_checker.sv
tb/tb_bch_t4_error_locator.sv
